FILE: src/asc_pkg.sv
// shared types, field layout and codes for the attribute set closure block
package asc_pkg;

  localparam int ATTR_COUNT_DEF = 32;
  localparam int RULE_SLOTS_DEF = 16;

  localparam int FIELD_W = 32;
  localparam int SLOT_W  = 4;
  localparam int RC_W    = 5;

  // s_tdata layout, lowest bit first
  localparam int SLOT_LSB  = 0;
  localparam int LHS_LSB   = SLOT_LSB + SLOT_W;
  localparam int RHS_LSB   = LHS_LSB + FIELD_W;
  localparam int START_LSB = RHS_LSB + FIELD_W;
  localparam int S_USED_W  = START_LSB + FIELD_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;
    logic start;
    logic step;
    logic capture;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic done;
    logic out_valid;
  } stat_t;

endpackage

FILE: src/asc_ctrl.sv
// controller state machine: sequences loads, closure passes and result capture
module asc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          s_tuser,
  input  logic          m_tready,
  input  asc_pkg::stat_t status,
  output asc_pkg::ctl_t  ctl
);

  asc_pkg::state_t state, state_next;
  logic s_accept;
  logic out_free;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !status.out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      asc_pkg::ST_IDLE: begin
        if (s_accept && (s_tuser == asc_pkg::MODE_QUERY)) state_next = asc_pkg::ST_RUN;
      end
      asc_pkg::ST_RUN: begin
        if (status.done && out_free) state_next = asc_pkg::ST_IDLE;
      end
      default: state_next = asc_pkg::ST_IDLE;
    endcase
  end

  // idle always takes a request, so a valid request is an accepted one there
  always_comb begin
    s_tready    = 1'b0;
    ctl         = '0;
    case (state)
      asc_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        ctl.load_wr = s_tvalid && (s_tuser == asc_pkg::MODE_LOAD);
        ctl.start   = s_tvalid && (s_tuser == asc_pkg::MODE_QUERY);
      end
      asc_pkg::ST_RUN: begin
        ctl.step    = 1'b1;
        ctl.capture = status.done && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/asc_datapath.sv
// datapath: rule table, working set with one parallel pass per cycle, result register
module asc_datapath #(
  parameter int ATTR_COUNT = asc_pkg::ATTR_COUNT_DEF,
  parameter int RULE_SLOTS = asc_pkg::RULE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [asc_pkg::RC_W-1:0]      cfg_data,
  input  logic [asc_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          m_tready,
  input  asc_pkg::ctl_t                 ctl,
  output asc_pkg::stat_t                status,
  output logic                          m_tvalid,
  output logic [asc_pkg::FIELD_W-1:0]   m_tdata
);

  localparam int SET_W = (ATTR_COUNT < asc_pkg::FIELD_W) ? ATTR_COUNT : asc_pkg::FIELD_W;
  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  logic [asc_pkg::RC_W-1:0]   rule_count;
  logic [SET_W-1:0]           lhs_store [RULE_SLOTS];
  logic [SET_W-1:0]           rhs_store [RULE_SLOTS];
  logic [SET_W-1:0]           work;
  logic [SET_W-1:0]           gain;
  logic [SET_W-1:0]           work_next;
  logic [asc_pkg::FIELD_W-1:0] out_reg;
  logic                       out_valid;

  logic [asc_pkg::SLOT_W-1:0] rule_slot;
  logic [SET_W-1:0]           lhs_in;
  logic [SET_W-1:0]           rhs_in;
  logic [SET_W-1:0]           start_in;
  logic                       slot_ok;
  logic [IDX_W-1:0]           widx;

  // upper attribute bits are dropped here when ATTR_COUNT is narrow
  assign rule_slot = s_tdata[asc_pkg::SLOT_LSB +: asc_pkg::SLOT_W];
  assign lhs_in    = s_tdata[asc_pkg::LHS_LSB +: SET_W];
  assign rhs_in    = s_tdata[asc_pkg::RHS_LSB +: SET_W];
  assign start_in  = s_tdata[asc_pkg::START_LSB +: SET_W];
  assign slot_ok   = 32'(rule_slot) < 32'(RULE_SLOTS);
  assign widx      = IDX_W'(rule_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_valid) begin
      rule_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr && slot_ok) begin
      lhs_store[widx] <= lhs_in;
      rhs_store[widx] <= rhs_in;
    end
  end

  // one pass: every active rule whose left side is covered contributes its right side;
  // counts above the table size enable every slot
  always_comb begin
    gain = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if ((int'(rule_count) > i) && ((lhs_store[i] & ~work) == '0)) begin
        gain = gain | rhs_store[i];
      end
    end
  end

  assign work_next   = work | gain;
  assign status.done = (work_next == work);

  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
    end else if (ctl.start) begin
      work <= start_in;
    end else if (ctl.step) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.capture) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      out_reg <= asc_pkg::FIELD_W'(work);
    end
  end

  assign status.out_valid = out_valid;
  assign m_tvalid         = out_valid;
  assign m_tdata          = out_reg;

  a_capture_at_fixpoint: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> status.done)
    else $error("result captured before the set stopped growing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> (!out_valid || m_tready))
    else $error("pending result overwritten");

  a_set_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && !ctl.start) |=> ((work & $past(work)) == $past(work)))
    else $error("working set lost an attribute during a pass");

endmodule

FILE: src/attribute_set_closure.sv
// top level: attribute set closure under a loaded table of functional dependencies
// a load request is written from idle and keeps the block idle; a query runs passes
//   after accept, first those that still add attributes (at most ATTR_COUNT), then
//   a last pass finding nothing new; each pass checks all rules at once
// the next request is taken the cycle after the result is captured, which waits while
//   a previous result is still pending; a result waits in its own register while loads go on
// rst (synchronous, active high) clears rule_count, the working set and the controller;
//   the rule table is not cleared and a slot must be loaded before a query uses it
module attribute_set_closure #(
  parameter int ATTR_COUNT = asc_pkg::ATTR_COUNT_DEF,
  parameter int RULE_SLOTS = asc_pkg::RULE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: rule_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asc_pkg::RC_W-1:0]      cfg_data,   // rule_count
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [asc_pkg::S_TDATA_W-1:0] s_tdata,    // rule_slot, lhs_mask, rhs_mask, start_set
  input  logic                          s_tuser,    // mode
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [asc_pkg::FIELD_W-1:0]   m_tdata     // closure_set
);

  asc_pkg::ctl_t  ctl;
  asc_pkg::stat_t status;

  // register writes must come only while idle (the block does not enforce it), so the channel is always open
  assign cfg_ready = 1'b1;

  // controller: idle takes loads and queries, run steps passes until the fixpoint
  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .ctl      (ctl)
  );

  // datapath: rule table, working set and result register
  asc_datapath #(
    .ATTR_COUNT (ATTR_COUNT),
    .RULE_SLOTS (RULE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .ctl       (ctl),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: verif/tb_attribute_set_closure.sv
// testbench for attribute_set_closure: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_attribute_set_closure;

  // wait after the owed closures have arrived, so a trailing load finishes; margin on top
  localparam int SETTLE_CYCLES = asc_pkg::ATTR_COUNT_DEF + 8;
  localparam int PHASE_ITEMS   = 170;
  localparam int MAX_SHOWN     = 10;

  typedef logic [asc_pkg::SLOT_W-1:0] slot_t;
  typedef logic [asc_pkg::RC_W-1:0]   count_t;

  // one request as the sender sees it, before packing
  typedef struct packed {
    logic                        mode;
    logic [asc_pkg::SLOT_W-1:0]  slot;
    logic [asc_pkg::FIELD_W-1:0] lhs;
    logic [asc_pkg::FIELD_W-1:0] rhs;
    logic [asc_pkg::FIELD_W-1:0] start;
  } request_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [asc_pkg::RC_W-1:0]      cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [asc_pkg::S_TDATA_W-1:0] s_tdata;   // rule_slot, lhs_mask, rhs_mask, start_set
  logic                          s_tuser;   // mode
  logic                          m_tvalid;
  logic                          m_tready;
  logic [asc_pkg::FIELD_W-1:0]   m_tdata;   // closure_set

  // predictor state: own copy of the rule table and rule_count
  logic [asc_pkg::FIELD_W-1:0] lhs_rules [asc_pkg::RULE_SLOTS_DEF];
  logic [asc_pkg::FIELD_W-1:0] rhs_rules [asc_pkg::RULE_SLOTS_DEF];
  logic [asc_pkg::RC_W-1:0]    rule_count_q;

  // closures still owed by the block, oldest first
  logic [asc_pkg::FIELD_W-1:0] closure_q [$];

  int unsigned mismatches;
  int unsigned idle_pct;   // percent chance that the sender idles again before a request
  int unsigned stall_pct;  // percent chance that the receiver stalls at each decision

  attribute_set_closure u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixpoint of the rule table over the active rules, passes until nothing is added
  function automatic logic [asc_pkg::FIELD_W-1:0] predict_closure(
      input logic [asc_pkg::FIELD_W-1:0] seed);
    logic [asc_pkg::FIELD_W-1:0] cur;
    logic [asc_pkg::FIELD_W-1:0] prev;
    int                          active;
    cur    = seed;
    active = (rule_count_q > asc_pkg::RULE_SLOTS_DEF) ? asc_pkg::RULE_SLOTS_DEF
                                                       : int'(rule_count_q);
    prev   = ~cur;
    while (cur != prev) begin
      prev = cur;
      for (int i = 0; i < active; i++) begin
        // rule fires when its left side is already inside the set
        if ((lhs_rules[i] & ~cur) == '0) cur = cur | rhs_rules[i];
      end
    end
    return cur;
  endfunction

  // few set bits so that rules actually chain, with the odd dense or full mask
  function automatic logic [asc_pkg::FIELD_W-1:0] sparse_set(input int unsigned max_bits);
    logic [asc_pkg::FIELD_W-1:0] s;
    int unsigned                 pick;
    int unsigned                 nbits;
    int unsigned                 idx;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '1;
    if (pick == 1) return $urandom;
    if (pick == 2) return '0;
    s     = '0;
    nbits = $urandom_range(0, max_bits);
    for (int unsigned k = 0; k < nbits; k++) begin
      // lean on the low byte half the time so rules overlap
      idx = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                 : $urandom_range(0, asc_pkg::FIELD_W - 1);
      s[idx] = 1'b1;
    end
    return s;
  endfunction

  // one request: optional random gap, then hold until accepted, then predict a query or copy a load
  task automatic send_request(input request_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata                                            = '0;
    s_tdata[asc_pkg::SLOT_LSB +: asc_pkg::SLOT_W]      = req.slot;
    s_tdata[asc_pkg::LHS_LSB +: asc_pkg::FIELD_W]      = req.lhs;
    s_tdata[asc_pkg::RHS_LSB +: asc_pkg::FIELD_W]      = req.rhs;
    s_tdata[asc_pkg::START_LSB +: asc_pkg::FIELD_W]    = req.start;
    s_tuser                                            = req.mode;
    s_tvalid                                           = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req.mode == asc_pkg::MODE_QUERY) begin
      closure_q.push_back(predict_closure(req.start));
    end else begin
      lhs_rules[req.slot] = req.lhs;
      rhs_rules[req.slot] = req.rhs;
    end
  endtask

  // stop sending, let every owed closure arrive, then let a trailing load finish
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (closure_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // rule_count is only written while the block has nothing in flight
  task automatic set_rule_count(input logic [asc_pkg::RC_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rule_count_q = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic request_t make_query(input logic [asc_pkg::FIELD_W-1:0] start);
    request_t r;
    // fields a query ignores still carry noise
    r.mode  = asc_pkg::MODE_QUERY;
    r.slot  = slot_t'($urandom);
    r.lhs   = $urandom;
    r.rhs   = $urandom;
    r.start = start;
    return r;
  endfunction

  function automatic request_t make_load(input logic [asc_pkg::SLOT_W-1:0] slot,
                                         input logic [asc_pkg::FIELD_W-1:0] lhs,
                                         input logic [asc_pkg::FIELD_W-1:0] rhs);
    request_t r;
    r.mode  = asc_pkg::MODE_LOAD;
    r.slot  = slot;
    r.lhs   = lhs;
    r.rhs   = rhs;
    r.start = $urandom;  // ignored by a load
    return r;
  endfunction

  // with no rules taking part the closure is the start set itself
  task automatic test_empty_rule_count();
    send_request(make_query('0));
    send_request(make_query('1));
  endtask

  // fill every slot with a chain: slot 15 fires on an empty left side and gives bit 15,
  // then each slot i turns bit i+1 into bit i, one new bit per pass
  task automatic test_load_chain();
    for (int i = 0; i < asc_pkg::RULE_SLOTS_DEF; i++) begin
      if (i == asc_pkg::RULE_SLOTS_DEF - 1) send_request(make_load(slot_t'(i), '0, 32'h1 << i));
      else send_request(make_load(slot_t'(i), 32'h1 << (i + 1), 32'h1 << i));
    end
  endtask

  // longest pass count, full start set, top attribute bit, partial rule counts
  task automatic test_chain_queries();
    set_rule_count(count_t'(asc_pkg::RULE_SLOTS_DEF));
    send_request(make_query('0));
    send_request(make_query('1));
    send_request(make_query(32'h8000_0000));
    set_rule_count(count_t'(asc_pkg::RULE_SLOTS_DEF - 1));
    send_request(make_query('0));
    send_request(make_query(32'h0000_8000));
    set_rule_count(count_t'(1));
    send_request(make_query(32'h0000_0002));
  endtask

  // rule_count past the table size behaves like the full table
  task automatic test_large_rule_count();
    set_rule_count('1);
    send_request(make_query('0));
  endtask

  function automatic logic [asc_pkg::RC_W-1:0] pick_rule_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return count_t'(1);
      2: return count_t'(asc_pkg::RULE_SLOTS_DEF - 1);
      3: return count_t'(asc_pkg::RULE_SLOTS_DEF);
      4: return '1;
      default: return count_t'($urandom_range(0, (1 << asc_pkg::RC_W) - 1));
    endcase
  endfunction

  // random loads and queries; all slots are already written so any rule_count is legal
  task automatic test_random_phase(input int unsigned idle, input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    set_rule_count(pick_rule_count());
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // halfway the sender drains completely and the rule count moves
      if (n == PHASE_ITEMS / 2) set_rule_count(pick_rule_count());
      if ($urandom_range(0, 9) < 3) begin
        send_request(make_load(slot_t'($urandom_range(0, asc_pkg::RULE_SLOTS_DEF - 1)),
                               sparse_set(2), sparse_set(3)));
      end else begin
        send_request(make_query(sparse_set(4)));
      end
    end
  endtask

  // receiver: random stalls decided at the falling edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker: every accepted closure against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (closure_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected closure %h with nothing pending", m_tdata);
      end else begin
        if (m_tdata !== closure_q[0]) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("closure mismatch: expected %h got %h", closure_q[0], m_tdata);
        end
        void'(closure_q.pop_front());
      end
    end
  end

  // main sequence
  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = asc_pkg::MODE_LOAD;
    rule_count_q = '0;
    mismatches   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    for (int i = 0; i < asc_pkg::RULE_SLOTS_DEF; i++) begin
      lhs_rules[i] = '0;
      rhs_rules[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_rule_count();
    test_load_chain();
    test_chain_queries();
    test_large_rule_count();
    test_random_phase(0, 0);
    test_random_phase(84, 0);
    test_random_phase(0, 84);
    test_random_phase(9, 9);

    wait_idle();
    if (mismatches == 0) begin
      $display("attribute_set_closure test passed");
    end else begin
      $display("attribute_set_closure test failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("attribute_set_closure test failed");
    $finish;
  end

endmodule

FILE: files.f
src/asc_pkg.sv
src/asc_ctrl.sv
src/asc_datapath.sv
src/attribute_set_closure.sv
verif/tb_attribute_set_closure.sv
